// ----- rtl/core/dtwsl_pkg.sv -----
// Shared types and constants of the DDS tuning word serial loader.
package dtwsl_pkg;

    // Field widths and frame layout
    localparam int unsigned FREQ_W     = 32;
    localparam int unsigned TW_W       = 32;
    localparam int unsigned CTRL_BITS  = 8;
    localparam int unsigned FRAME_BITS = TW_W + CTRL_BITS;
    localparam int unsigned BEAT_W     = $clog2(FRAME_BITS + 1);

    // Reset values of the stored state
    localparam logic [FREQ_W-1:0] RESET_FREQ = 32'd1_000_000;
    localparam logic [FREQ_W-1:0] RESET_MAX  = 32'd40_000_000;

    // Tuning word divider: f * (2^32 - 1) / 125 MHz, with 125 MHz = 2^6 * 5^9.
    // The 2^6 part is a shift; the 5^9 part is long division one byte at a
    // time, each quotient byte taken exactly from a reciprocal multiply.
    localparam int unsigned        NUM_W       = 2 * FREQ_W;
    localparam int unsigned        CLK_SHIFT   = 6;
    localparam int unsigned        DIV_D_W     = 21;
    localparam logic [DIV_D_W-1:0] DIV_D       = 21'd1_953_125;
    localparam int unsigned        DIG_W       = 8;
    localparam int unsigned        NUM_DIGITS  = NUM_W / DIG_W;
    localparam int unsigned        DIG_CNT_W   = $clog2(NUM_DIGITS);
    localparam int unsigned        PART_W      = DIV_D_W + DIG_W;
    localparam int unsigned        RECIP_W     = 30;
    localparam logic [RECIP_W-1:0] RECIP       = 30'd576_460_753; // ceil(2^50 / 5^9)
    localparam int unsigned        RECIP_SHIFT = 50;
    localparam int unsigned        PROD_W      = PART_W + RECIP_W;

    // Command queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // Command codes
    typedef enum logic [1:0] {
        OP_SET     = 2'd0,
        OP_ENABLE  = 2'd1,
        OP_DISABLE = 2'd2
    } t_op;

    // Classified command, front to back
    typedef struct packed {
        logic              send;
        logic [FREQ_W-1:0] send_val;
        logic [FREQ_W-1:0] freq_now;
        logic              output_on;
    } t_cmd;

    // Command with its tuning word, divider to serializer
    typedef struct packed {
        logic              send;
        logic [TW_W-1:0]   tw;
        logic [FREQ_W-1:0] freq_now;
        logic              output_on;
    } t_frame;

endpackage

// ----- rtl/core/dtwsl_front.sv -----
// Front end: accepts commands, keeps frequency, enable flag and limit, classifies.
module dtwsl_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [dtwsl_pkg::FREQ_W-1:0] i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_operation,
    input  logic [dtwsl_pkg::FREQ_W-1:0] i_freq_hz,
    input  logic                         i_q_full,
    output logic                         o_push,
    output dtwsl_pkg::t_cmd              o_cmd
);
    import dtwsl_pkg::*;

    logic [FREQ_W-1:0] r_max;
    logic [FREQ_W-1:0] r_freq;
    logic              r_en;
    logic [FREQ_W-1:0] n_freq;
    logic              n_en;
    logic              send;
    logic [FREQ_W-1:0] send_val;
    logic              accept;

    assign accept  = i_valid && !i_q_full;
    assign o_stall = i_q_full;
    assign o_push  = accept;

    // Command decode and state update
    always_comb begin
        n_freq   = r_freq;
        n_en     = r_en;
        send     = 1'b0;
        send_val = '0;
        unique case (t_op'(i_operation))
            OP_SET: begin
                if (i_freq_hz <= r_max) begin
                    n_freq   = i_freq_hz;
                    send     = r_en;
                    send_val = i_freq_hz;
                end
            end
            OP_ENABLE: begin
                n_en     = 1'b1;
                send     = 1'b1;
                send_val = r_freq;
            end
            OP_DISABLE: begin
                n_en     = 1'b0;
                send     = 1'b1;
                send_val = '0;
            end
            default: begin
                // reserved code: no change, status only
            end
        endcase
    end

    assign o_cmd = '{send: send, send_val: send_val, freq_now: n_freq, output_on: n_en};

    // State and limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max  <= RESET_MAX;
            r_freq <= RESET_FREQ;
            r_en   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            if (accept) begin
                r_freq <= n_freq;
                r_en   <= n_en;
            end
        end
    end

endmodule

// ----- rtl/core/dtwsl_queue.sv -----
// Short command queue between the front end and the back end.
module dtwsl_queue #(
    parameter int unsigned DEPTH = dtwsl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dtwsl_pkg::t_cmd i_push_cmd,
    output logic            o_full,
    output logic            o_pop_valid,
    output dtwsl_pkg::t_cmd o_pop_cmd,
    input  logic            i_pop
);
    import dtwsl_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full      = (r_cnt == CNT_W'(DEPTH));
    assign o_pop_valid = (r_cnt != '0);
    assign o_pop_cmd   = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue push while full");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_pop_valid) else $error("queue pop while empty");

endmodule

// ----- rtl/core/dtwsl_div.sv -----
// Back end, first stage: tuning word by byte-wise long division with a reciprocal multiply.
module dtwsl_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  dtwsl_pkg::t_cmd   i_cmd,
    output logic              o_take,
    output logic              o_valid,
    output dtwsl_pkg::t_frame o_frame,
    input  logic              i_take
);
    import dtwsl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EST  = 4'b0010,
        S_FIX  = 4'b0100,
        S_DONE = 4'b1000
    } t_div_state;

    t_div_state           r_state;
    t_div_state           n_state;
    t_cmd                 r_cmd;
    logic [NUM_W-1:0]     r_num;
    logic [DIV_D_W-1:0]   r_rem;
    logic [PART_W-1:0]    r_part;
    logic [DIG_W-1:0]     r_qdig;
    logic [TW_W-1:0]      r_quo;
    logic [DIG_CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]     numer;
    logic [PART_W-1:0]    part;
    logic [PROD_W-1:0]    prod;
    logic [PART_W-1:0]    qd;
    logic [PART_W-1:0]    diff;

    // Take a new command when empty or when the finished one leaves this cycle
    assign o_take  = i_valid && ((r_state == S_IDLE) || ((r_state == S_DONE) && i_take));
    assign o_valid = (r_state == S_DONE);
    assign o_frame = '{send: r_cmd.send, tw: r_quo, freq_now: r_cmd.freq_now,
                       output_on: r_cmd.output_on};

    // f * (2^32 - 1) as (f << 32) - f
    assign numer = {i_cmd.send_val, {FREQ_W{1'b0}}} - {{FREQ_W{1'b0}}, i_cmd.send_val};

    // Quotient byte estimate: exact for any partial dividend below 256 * 5^9
    assign part = {r_rem, r_num[NUM_W-1 -: DIG_W]};
    assign prod = {{RECIP_W{1'b0}}, part} * {{PART_W{1'b0}}, RECIP};

    // Remainder after the quotient byte
    assign qd   = {{DIV_D_W{1'b0}}, r_qdig} * {{DIG_W{1'b0}}, DIV_D};
    assign diff = r_part - qd;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_take) begin
                    n_state = i_cmd.send ? S_EST : S_DONE;
                end
            end
            S_EST: begin
                n_state = S_FIX;
            end
            S_FIX: begin
                n_state = (r_cnt == '0) ? S_DONE : S_EST;
            end
            S_DONE: begin
                if (o_take) begin
                    n_state = i_cmd.send ? S_EST : S_DONE;
                end else if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Divider datapath: an estimate step and a fix step per quotient byte, most significant first
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_cmd <= i_cmd;
            r_num <= numer >> CLK_SHIFT;
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= DIG_CNT_W'(NUM_DIGITS - 1);
        end else if (r_state == S_EST) begin
            r_part <= part;
            r_qdig <= prod[RECIP_SHIFT +: DIG_W];
            r_num  <= r_num << DIG_W;
        end else if (r_state == S_FIX) begin
            r_rem <= diff[DIV_D_W-1:0];
            r_quo <= {r_quo[TW_W-DIG_W-1:0], r_qdig};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && !i_take |=> (r_state == S_DONE) && $stable(r_quo))
        else $error("finished tuning word lost before handoff");

endmodule

// ----- rtl/core/dtwsl_ser.sv -----
// Back end, second stage: shifts out the frame one beat per cycle unless stalled, then status.
module dtwsl_ser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  dtwsl_pkg::t_frame            i_frame,
    output logic                         o_take,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_kind,
    output logic                         o_serial_bit,
    output logic [dtwsl_pkg::FREQ_W-1:0] o_freq_now,
    output logic                         o_output_on,
    output logic                         o_last
);
    import dtwsl_pkg::*;

    logic              r_full;
    logic [BEAT_W-1:0] r_left;
    logic [TW_W-1:0]   r_tw;
    logic [FREQ_W-1:0] r_freq;
    logic              r_on;
    logic              beat;
    logic              done;

    assign beat   = r_full && !i_stall;
    assign done   = beat && (r_left == '0);
    assign o_take = i_valid && (!r_full || done);

    assign o_valid      = r_full;
    assign o_kind       = (r_left == '0);
    assign o_last       = (r_left == '0);
    assign o_serial_bit = r_tw[0];
    assign o_freq_now   = r_freq;
    assign o_output_on  = r_on;

    // Beat counter: data beats left before the closing status beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_left <= '0;
        end else begin
            if (o_take) begin
                r_full <= 1'b1;
                r_left <= i_frame.send ? BEAT_W'(FRAME_BITS) : '0;
            end else begin
                if (done) begin
                    r_full <= 1'b0;
                end
                if (beat && (r_left != '0)) begin
                    r_left <= r_left - 1'b1;
                end
            end
        end
    end

    // Shift register, LSB first; zeros fill in for the control bits
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_tw   <= i_frame.send ? i_frame.tw : '0;
            r_freq <= i_frame.freq_now;
            r_on   <= i_frame.output_on;
        end else if (beat) begin
            r_tw <= r_tw >> 1;
        end
    end

    a_status_bit_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> !o_serial_bit) else $error("data bit set on status beat");

    a_left_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= BEAT_W'(FRAME_BITS)) else $error("beat counter out of range");

endmodule

// ----- rtl/core/dds_tuning_word_serial_loader_core.sv -----
// Top level of the DDS tuning word serial loader.
//
// Usage:
//   Input channel (i_valid / o_stall): one command per beat, i_operation 0 sets
//   the frequency (i_freq_hz, taken only if not above the limit), 1 enables,
//   2 disables. Limit register: write i_cfg_wdata with i_cfg_we while idle.
//   Output channel (o_valid / i_stall): a command that sends a frame gives 40
//   data beats (32 tuning word bits LSB first, 8 zero control bits), then one
//   status beat with o_kind = o_last = 1. Other commands give the status beat.
//   A status-only command passes the queue, the divider's done state and the
//   serializer; a framed command passes the queue, the divider's estimate and
//   fix steps for each quotient byte and the handoff before its first data beat.
//   Throughput: framed commands are bound by the serializer's one beat per
//   cycle while the receiver does not stall (the divider runs on the next
//   command meanwhile); status-only commands follow back to back.
//   Reset (synchronous, active low): frequency 1 MHz, output disabled, limit
//   40 MHz, queue and pipeline empty.
//   When the receiver stalls, the output beat holds and the queue fills; then
//   o_stall rises and commands wait upstream.
module dds_tuning_word_serial_loader_core #(
    parameter int unsigned QUEUE_DEPTH = dtwsl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [dtwsl_pkg::FREQ_W-1:0] i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_operation,
    input  logic [dtwsl_pkg::FREQ_W-1:0] i_freq_hz,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_kind,
    output logic                         o_serial_bit,
    output logic [dtwsl_pkg::FREQ_W-1:0] o_freq_now,
    output logic                         o_output_on,
    output logic                         o_last
);
    import dtwsl_pkg::*;

    logic   push;
    t_cmd   push_cmd;
    logic   q_full;
    logic   q_valid;
    t_cmd   q_cmd;
    logic   q_pop;
    logic   div_valid;
    t_frame div_frame;
    logic   ser_take;

    // Front end
    dtwsl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_freq_hz   (i_freq_hz),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // Command queue
    dtwsl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_cmd  (push_cmd),
        .o_full      (q_full),
        .o_pop_valid (q_valid),
        .o_pop_cmd   (q_cmd),
        .i_pop       (q_pop)
    );

    // Tuning word divider
    dtwsl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .o_take  (q_pop),
        .o_valid (div_valid),
        .o_frame (div_frame),
        .i_take  (ser_take)
    );

    // Frame serializer
    dtwsl_ser u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (div_valid),
        .i_frame      (div_frame),
        .o_take       (ser_take),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_serial_bit (o_serial_bit),
        .o_freq_now   (o_freq_now),
        .o_output_on  (o_output_on),
        .o_last       (o_last)
    );

endmodule
